FILE: hw/rtl/ljpi_pkg.sv
// Shared types, constants and helper functions for the Lennard-Jones pair impulse pipeline.
// Used by every module under hw/rtl; depends on nothing else.
`default_nettype none

package ljpi_pkg;

    // field and datapath widths
    localparam int POS_W     = 32;
    localparam int BOX_W     = 31;
    localparam int TS_W      = 24;
    localparam int A_W       = 25;
    localparam int R2_W      = 50;
    localparam int P_W       = 49;
    localparam int DIV_BITS  = 32;
    localparam int SCALE_LAT = 3;
    localparam int MAG_W     = 31;

    localparam logic [BOX_W-1:0] BOX_RESET     = 31'd65536;
    localparam logic [BOX_W-1:0] CUTOFF_RESET  = 31'd589824;
    localparam logic [TS_W-1:0]  TS_RESET      = 24'd83886;
    localparam logic [33:0]      FAR_LIMIT     = 34'h1000000;
    localparam logic [R2_W-1:0]  NEAR_LIMIT    = 50'h1000000;
    localparam logic [MAG_W-1:0] MAX_MAG       = 31'h7FFFFFFF;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_BOX_WIDTH  = 2'd0,
        CFG_BOX_HEIGHT = 2'd1,
        CFG_CUTOFF_SQ  = 2'd2,
        CFG_TIME_STEP  = 2'd3
    } t_cfg_index;

    // per-item side information carried down the pipeline
    typedef struct packed {
        logic                  vld;
        logic                  in_cut;
        logic                  near;
        logic [1:0]            dneg;
        logic [1:0]            pnz;
        logic                  yneg;
        logic                  ynz;
        logic [6:0]            e;
        logic [1:0][P_W-1:0]   p;
    } t_ctx;

    // one result item
    typedef struct packed {
        logic [POS_W-1:0] impulse_x;
        logic [POS_W-1:0] impulse_y;
        logic             within_cutoff;
        logic             saturated;
    } t_result;

    // bit length of a 16 bit chunk
    function automatic logic [4:0] chunk_len(input logic [15:0] w);
        logic [4:0] len;
        len = '0;
        for (int i = 0; i < 16; i++) begin
            if (w[i]) begin
                len = 5'(i + 1);
            end
        end
        return len;
    endfunction

    // bit length of a 64 bit word from its four chunk lengths
    function automatic logic [6:0] join_len(input logic [3:0][4:0] cl);
        logic [6:0] len;
        if (cl[3] != '0) begin
            len = 7'd48 + 7'(cl[3]);
        end else if (cl[2] != '0) begin
            len = 7'd32 + 7'(cl[2]);
        end else if (cl[1] != '0) begin
            len = 7'd16 + 7'(cl[1]);
        end else begin
            len = 7'(cl[0]);
        end
        return len;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ljpi_recip.sv
// Pipelined restoring divider: floor((2^63-1) / divisor), one quotient bit per stage.
// Depends on ljpi_pkg.
`default_nettype none

module ljpi_recip import ljpi_pkg::*; (
    input  logic                i_clk,
    input  logic                i_ce,
    input  logic [DIV_BITS-1:0] i_divisor,
    output logic [DIV_BITS-1:0] o_quotient
);

    logic [DIV_BITS-1:0] r_rem [DIV_BITS-1];
    logic [DIV_BITS-1:0] r_div [DIV_BITS-1];
    logic [DIV_BITS-1:0] r_q   [DIV_BITS];

    for (genvar k = 0; k < DIV_BITS; k++) begin : g_stage
        logic [DIV_BITS-1:0] w_rem_in;
        logic [DIV_BITS-1:0] w_div_in;
        logic [DIV_BITS-1:0] w_q_in;
        logic [DIV_BITS:0]   w_trial;
        logic [DIV_BITS-1:0] n_rem;
        logic [DIV_BITS-1:0] n_q;

        // stage inputs: the first stage starts from the upper dividend bits
        if (k == 0) begin : g_first
            assign w_rem_in = {1'b0, {(DIV_BITS-1){1'b1}}};
            assign w_div_in = i_divisor;
            assign w_q_in   = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_div_in = r_div[k-1];
            assign w_q_in   = r_q[k-1];
        end

        // bring down a one bit of the dividend and try the subtract
        assign w_trial = {w_rem_in, 1'b1};

        always_comb begin
            if (w_trial >= {1'b0, w_div_in}) begin
                n_rem = DIV_BITS'(w_trial - {1'b0, w_div_in});
                n_q   = {w_q_in[DIV_BITS-2:0], 1'b1};
            end else begin
                n_rem = w_trial[DIV_BITS-1:0];
                n_q   = {w_q_in[DIV_BITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_q[k] <= n_q;
            end
        end

        // remainder and divisor go on to the next stage
        if (k < DIV_BITS - 1) begin : g_pass
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_rem[k] <= n_rem;
                    r_div[k] <= w_div_in;
                end
            end
        end
    end

    assign o_quotient = r_q[DIV_BITS-1];

endmodule

`default_nettype wire

FILE: hw/rtl/ljpi_scale.sv
// Three-stage scaler: floor(p * y / 2^sh) with overflow detection, split multiply.
// Depends on ljpi_pkg.
`default_nettype none

module ljpi_scale import ljpi_pkg::*; (
    input  logic               i_clk,
    input  logic               i_ce,
    input  logic [P_W-1:0]     i_p,
    input  logic [31:0]        i_y,
    input  logic signed [8:0]  i_sh,
    output logic [MAG_W-1:0]   o_mag,
    output logic               o_ovf
);

    logic [63:0]        r1_lo;
    logic [48:0]        r1_hi;
    logic signed [8:0]  r1_sh;
    logic [81:0]        r2_prod;
    logic signed [8:0]  r2_sh;
    logic [MAG_W-1:0]   r3_mag;
    logic               r3_ovf;
    logic [81:0]        w_shifted;
    logic               w_ovf;

    // partial products of the 49 by 32 multiply
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_lo <= 64'(i_p[31:0]) * 64'(i_y);
            r1_hi <= 49'(i_p[P_W-1:32]) * 49'(i_y);
            r1_sh <= i_sh;
        end
    end

    // combine into the full product
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r2_prod <= (82'(r1_hi) << 32) + 82'(r1_lo);
            r2_sh   <= r1_sh;
        end
    end

    // scale down, flag anything at or above 2^31
    always_comb begin
        w_shifted = r2_prod >> r2_sh[7:0];
        w_ovf     = r2_sh[8] | (|w_shifted[81:31]);
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r3_mag <= w_shifted[MAG_W-1:0];
            r3_ovf <= w_ovf;
        end
    end

    assign o_mag = r3_mag;
    assign o_ovf = r3_ovf;

endmodule

`default_nettype wire

FILE: hw/rtl/ljpi_skid.sv
// Output register with one skid entry; the pipeline enable comes from a register only.
// Depends on ljpi_pkg.
`default_nettype none

module ljpi_skid import ljpi_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_data,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_ready
);

    logic    r_ov;
    logic    r_sv;
    t_result r_od;
    t_result r_sd;

    assign o_ready = ~r_sv;

    // output and skid occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || i_ready) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end else begin
                r_ov <= i_valid;
            end
        end else if (i_valid && !r_sv) begin
            r_sv <= 1'b1;
        end
    end

    // payload moves
    always_ff @(posedge i_clk) begin
        if (!r_ov || i_ready) begin
            if (r_sv) begin
                r_od <= r_sd;
            end else if (i_valid) begin
                r_od <= i_data;
            end
        end else if (i_valid && !r_sv) begin
            r_sd <= i_data;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_od;

    // a parked item always has an item in front of it
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_sv |-> r_ov)
        else $error("skid entry full while output register empty");

endmodule

`default_nettype wire

FILE: hw/rtl/lennard_jones_pair_impulse.sv
// Top level of the 2D Lennard-Jones pair impulse pipeline with periodic box and cutoff.
// Depends on ljpi_pkg, ljpi_recip, ljpi_scale and ljpi_skid.
`default_nettype none

// One pair is taken per clock while the pipeline is not held, and one result comes out per
// pair, in order. The pair passes 51 register stages: eight stages for the separation,
// squared distance and normalization, 32 stages of the bit-per-stage reciprocal divider,
// seven stages for the powers of 1/r^2 and the forming and fitting of Y, three scaling
// stages and the output register. When the output stalls, one more result is still parked
// in the skid entry, then the whole pipeline holds. The user must write the configuration
// registers only while idle; the block itself does not enforce this.
module lennard_jones_pair_impulse import ljpi_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // first_x, first_y, second_x, second_y
    input  logic [127:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // impulse_x, impulse_y
    output logic [63:0]  o_m_axis_tdata,
    // within_cutoff, saturated
    output logic [1:0]   o_m_axis_tuser,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [30:0]  i_cfg_data
);

    logic [BOX_W-1:0] r_box_w;
    logic [BOX_W-1:0] r_box_h;
    logic [BOX_W-1:0] r_cut;
    logic [TS_W-1:0]  r_ts;
    logic             w_ce;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_w <= BOX_RESET;
            r_box_h <= BOX_RESET;
            r_cut   <= CUTOFF_RESET;
            r_ts    <= TS_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_BOX_WIDTH:  r_box_w <= i_cfg_data;
                CFG_BOX_HEIGHT: r_box_h <= i_cfg_data;
                CFG_CUTOFF_SQ:  r_cut   <= i_cfg_data;
                CFG_TIME_STEP:  r_ts    <= i_cfg_data[TS_W-1:0];
                default:        r_ts    <= r_ts;
            endcase
        end
    end

    assign o_s_axis_tready = w_ce;

    // minimum image correction along one axis
    function automatic logic [33:0] min_image(input logic [32:0] d, input logic [30:0] len);
        logic signed [34:0] d2;
        logic signed [34:0] l;
        logic [33:0]        r;
        d2 = $signed({d[32], d, 1'b0});
        l  = $signed({4'b0, len});
        r  = {d[32], d};
        if (d2 < -l) begin
            r = r + {3'b0, len};
        end else if (d2 > l) begin
            r = r - {3'b0, len};
        end
        return r;
    endfunction

    // stage 1: raw separation
    logic             r1_vld;
    logic [1:0][32:0] r1_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_ce) begin
            r1_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r1_d[0] <= {i_s_axis_tdata[95], i_s_axis_tdata[95:64]}
                     - {i_s_axis_tdata[31], i_s_axis_tdata[31:0]};
            r1_d[1] <= {i_s_axis_tdata[127], i_s_axis_tdata[127:96]}
                     - {i_s_axis_tdata[63], i_s_axis_tdata[63:32]};
        end
    end

    // stage 2: wrap into the box
    logic             r2_vld;
    logic [1:0][33:0] r2_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_ce) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r2_d[0] <= min_image(r1_d[0], r_box_w);
            r2_d[1] <= min_image(r1_d[1], r_box_h);
        end
    end

    // stage 3: magnitudes and far test
    logic                r3_vld;
    logic [1:0][A_W-1:0] r3_a;
    logic [1:0]          r3_dneg;
    logic                r3_far;
    logic [1:0][33:0]    w_abs;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_abs[k] = r2_d[k][33] ? (~r2_d[k] + 34'd1) : r2_d[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_ce) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int k = 0; k < 2; k++) begin
                r3_a[k]    <= w_abs[k][A_W-1:0];
                r3_dneg[k] <= r2_d[k][33];
            end
            r3_far <= (w_abs[0] > FAR_LIMIT) | (w_abs[1] > FAR_LIMIT);
        end
    end

    // stage 4: squares and time step products
    logic                 r4_vld;
    logic [1:0][R2_W-1:0] r4_sq;
    logic [1:0][P_W-1:0]  r4_p;
    logic [1:0]           r4_dneg;
    logic                 r4_far;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (w_ce) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int k = 0; k < 2; k++) begin
                r4_sq[k] <= R2_W'(r3_a[k]) * R2_W'(r3_a[k]);
                r4_p[k]  <= P_W'(r_ts) * P_W'(r3_a[k]);
            end
            r4_dneg <= r3_dneg;
            r4_far  <= r3_far;
        end
    end

    // stage 5: squared distance, cutoff and near tests
    t_ctx            r5_ctx;
    logic [R2_W-1:0] r5_r2;
    t_ctx            w5_ctx;
    logic [R2_W-1:0] w5_r2;

    always_comb begin
        w5_r2         = r4_sq[0] + r4_sq[1];
        w5_ctx        = '0;
        w5_ctx.vld    = r4_vld;
        w5_ctx.in_cut = ~r4_far & (w5_r2 <= {3'b0, r_cut, 16'b0});
        w5_ctx.near   = w5_r2 <= NEAR_LIMIT;
        w5_ctx.dneg   = r4_dneg;
        w5_ctx.pnz    = {r4_p[1] != '0, r4_p[0] != '0};
        w5_ctx.p      = r4_p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_ctx.vld <= 1'b0;
        end else if (w_ce) begin
            r5_ctx <= w5_ctx;
            r5_r2  <= w5_r2;
        end
    end

    // stage 6: chunk lengths of the squared distance
    t_ctx            r6_ctx;
    logic [R2_W-1:0] r6_r2;
    logic [3:0][4:0] r6_cl;
    logic [63:0]     w6_word;

    assign w6_word = {14'b0, r5_r2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_ctx.vld <= 1'b0;
        end else if (w_ce) begin
            r6_ctx <= r5_ctx;
            r6_r2  <= r5_r2;
            for (int c = 0; c < 4; c++) begin
                r6_cl[c] <= chunk_len(w6_word[16*c +: 16]);
            end
        end
    end

    // stage 7: bit length
    t_ctx            r7_ctx;
    logic [R2_W-1:0] r7_r2;
    logic [6:0]      r7_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_ctx.vld <= 1'b0;
        end else if (w_ce) begin
            r7_ctx <= r6_ctx;
            r7_r2  <= r6_r2;
            r7_len <= join_len(r6_cl);
        end
    end

    // stage 8: normalize into [2^31, 2^32)
    t_ctx                r8_ctx;
    logic [DIV_BITS-1:0] r8_m;
    logic [63:0]         w8_word;
    logic [DIV_BITS-1:0] w8_m;
    t_ctx                w8_ctx;

    always_comb begin
        w8_word = {14'b0, r7_r2};
        if (r7_len >= 7'd32) begin
            w8_m = DIV_BITS'(w8_word >> (r7_len - 7'd32));
        end else begin
            w8_m = DIV_BITS'(w8_word << (7'd32 - r7_len));
        end
        w8_ctx   = r7_ctx;
        w8_ctx.e = r7_len - 7'd32;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_ctx.vld <= 1'b0;
        end else if (w_ce) begin
            r8_ctx <= w8_ctx;
            r8_m   <= w8_m;
        end
    end

    // reciprocal divider with side information alongside
    logic [DIV_BITS-1:0] w_q;
    t_ctx                r_dctx [DIV_BITS];

    ljpi_recip u_recip (
        .i_clk      (i_clk),
        .i_ce       (w_ce),
        .i_divisor  (r8_m),
        .o_quotient (w_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_BITS; i++) begin
                r_dctx[i].vld <= 1'b0;
            end
        end else if (w_ce) begin
            r_dctx[0] <= r8_ctx;
            for (int i = 1; i < DIV_BITS; i++) begin
                r_dctx[i] <= r_dctx[i-1];
            end
        end
    end

    // stage 9: v and v^2 in Q.24
    t_ctx        r9_ctx;
    logic [24:0] r9_v;
    logic [25:0] r9_v2;
    logic [24:0] w9_v;

    assign w9_v = w_q[DIV_BITS-1:7];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_ctx.vld <= 1'b0;
        end else if (w_ce) begin
            r9_ctx <= r_dctx[DIV_BITS-1];
            r9_v   <= w9_v;
            r9_v2  <= 26'((50'(w9_v) * 50'(w9_v)) >> 24);
        end
    end

    // stage 10: v^3 and v^4
    t_ctx        r10_ctx;
    logic [26:0] r10_v3;
    logic [27:0] r10_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_ctx.vld <= 1'b0;
        end else if (w_ce) begin
            r10_ctx <= r9_ctx;
            r10_v3  <= 27'((51'(r9_v2) * 51'(r9_v)) >> 24);
            r10_v4  <= 28'((52'(r9_v2) * 52'(r9_v2)) >> 24);
        end
    end

    // stage 11: v^7
    t_ctx        r11_ctx;
    logic [30:0] r11_v7;
    logic [27:0] r11_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r11_ctx.vld <= 1'b0;
        end else if (w_ce) begin
            r11_ctx <= r10_ctx;
            r11_v7  <= 31'((55'(r10_v4) * 55'(r10_v3)) >> 24);
            r11_v4  <= r10_v4;
        end
    end

    // stage 12: 48*v^7 brought to the scale of 24*v^4
    t_ctx               r12_ctx;
    logic [63:0]        r12_big;
    logic [32:0]        r12_t24;
    logic [63:0]        w12_b48;
    logic signed [8:0]  w12_e9;
    logic signed [8:0]  w12_e3;
    logic [8:0]         w12_lsh;
    logic [63:0]        w12_big;

    always_comb begin
        w12_b48 = (64'(r11_v7) << 5) + (64'(r11_v7) << 4);
        w12_e9  = $signed({{2{r11_ctx.e[6]}}, r11_ctx.e});
        w12_e3  = w12_e9 + (w12_e9 <<< 1);
        w12_lsh = -w12_e3;
        if (w12_e3[8]) begin
            w12_big = w12_b48 << w12_lsh;
        end else begin
            w12_big = w12_b48 >> $unsigned(w12_e3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r12_ctx.vld <= 1'b0;
        end else if (w_ce) begin
            r12_ctx <= r11_ctx;
            r12_big <= w12_big;
            r12_t24 <= (33'(r11_v4) << 4) + (33'(r11_v4) << 3);
        end
    end

    // stage 13: Y and its magnitude
    t_ctx               r13_ctx;
    logic [63:0]        r13_ymag;
    logic signed [64:0] w13_y;
    logic [64:0]        w13_abs;
    t_ctx               w13_ctx;

    always_comb begin
        w13_y        = $signed({32'b0, r12_t24}) - $signed({1'b0, r12_big});
        w13_abs      = w13_y[64] ? 65'(-w13_y) : 65'(w13_y);
        w13_ctx      = r12_ctx;
        w13_ctx.yneg = w13_y[64];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r13_ctx.vld <= 1'b0;
        end else if (w_ce) begin
            r13_ctx  <= w13_ctx;
            r13_ymag <= w13_abs[63:0];
        end
    end

    // stage 14: chunk lengths of |Y|
    t_ctx            r14_ctx;
    logic [63:0]     r14_ymag;
    logic [3:0][4:0] r14_cl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r14_ctx.vld <= 1'b0;
        end else if (w_ce) begin
            r14_ctx  <= r13_ctx;
            r14_ymag <= r13_ymag;
            for (int c = 0; c < 4; c++) begin
                r14_cl[c] <= chunk_len(r13_ymag[16*c +: 16]);
            end
        end
    end

    // stage 15: fit |Y| into 32 bits and form the final shift
    t_ctx              r15_ctx;
    logic [31:0]       r15_y;
    logic signed [8:0] r15_sh;
    logic [6:0]        w15_len;
    logic [5:0]        w15_f;
    logic signed [8:0] w15_e9;
    t_ctx              w15_ctx;

    always_comb begin
        w15_len     = join_len(r14_cl);
        w15_f       = (w15_len > 7'd32) ? 6'(w15_len - 7'd32) : 6'd0;
        w15_e9      = $signed({{2{r14_ctx.e[6]}}, r14_ctx.e});
        w15_ctx     = r14_ctx;
        w15_ctx.ynz = r14_ymag != '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r15_ctx.vld <= 1'b0;
        end else if (w_ce) begin
            r15_ctx <= w15_ctx;
            r15_y   <= 32'(r14_ymag >> w15_f);
            r15_sh  <= 9'sd48 + (w15_e9 <<< 2) - $signed({3'b0, w15_f});
        end
    end

    // per-component scaling by time step and distance
    logic [1:0][MAG_W-1:0] w_mag;
    logic [1:0]            w_ovf;
    t_ctx                  r_sctx [SCALE_LAT];

    for (genvar k = 0; k < 2; k++) begin : g_scale
        ljpi_scale u_scale (
            .i_clk (i_clk),
            .i_ce  (w_ce),
            .i_p   (r15_ctx.p[k]),
            .i_y   (r15_y),
            .i_sh  (r15_sh),
            .o_mag (w_mag[k]),
            .o_ovf (w_ovf[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SCALE_LAT; i++) begin
                r_sctx[i].vld <= 1'b0;
            end
        end else if (w_ce) begin
            r_sctx[0] <= r15_ctx;
            for (int i = 1; i < SCALE_LAT; i++) begin
                r_sctx[i] <= r_sctx[i-1];
            end
        end
    end

    // result forming: cutoff, close-pair clipping, saturation and sign
    t_ctx                  w_fc;
    logic [1:0][MAG_W-1:0] w_fmag;
    logic [1:0]            w_fsat;
    logic [1:0]            w_fneg;
    logic [1:0][31:0]      w_fval;
    t_result               w_res;
    t_result               w_out;

    always_comb begin
        w_fc = r_sctx[SCALE_LAT-1];
        for (int k = 0; k < 2; k++) begin
            if (!w_fc.in_cut) begin
                w_fmag[k] = '0;
                w_fsat[k] = 1'b0;
                w_fneg[k] = 1'b0;
            end else if (w_fc.near) begin
                w_fmag[k] = w_fc.pnz[k] ? MAX_MAG : '0;
                w_fsat[k] = w_fc.pnz[k];
                w_fneg[k] = ~w_fc.dneg[k];
            end else if (!w_fc.pnz[k] || !w_fc.ynz) begin
                w_fmag[k] = '0;
                w_fsat[k] = 1'b0;
                w_fneg[k] = 1'b0;
            end else begin
                w_fmag[k] = w_ovf[k] ? MAX_MAG : w_mag[k];
                w_fsat[k] = w_ovf[k];
                w_fneg[k] = w_fc.yneg ^ w_fc.dneg[k];
            end
            w_fval[k] = w_fneg[k] ? (32'd0 - {1'b0, w_fmag[k]}) : {1'b0, w_fmag[k]};
        end
        w_res.impulse_x     = w_fval[0];
        w_res.impulse_y     = w_fval[1];
        w_res.within_cutoff = w_fc.in_cut;
        w_res.saturated     = |w_fsat;
    end

    ljpi_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fc.vld),
        .i_data  (w_res),
        .o_ready (w_ce),
        .o_valid (o_m_axis_tvalid),
        .o_data  (w_out),
        .i_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {w_out.impulse_y, w_out.impulse_x};
    assign o_m_axis_tuser = {w_out.saturated, w_out.within_cutoff};

    // beyond cutoff gives a zero, unsaturated result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata == '0 && !o_m_axis_tuser[1])
        else $error("nonzero result outside cutoff");

    // clipping is symmetric, so the most negative code never appears
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            o_m_axis_tdata[31:0] != 32'h80000000 && o_m_axis_tdata[63:32] != 32'h80000000)
        else $error("impulse outside symmetric range");

    // a saturated result has at least one component at full scale
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1] |->
            o_m_axis_tdata[31:0] == 32'h7FFFFFFF || o_m_axis_tdata[31:0] == 32'h80000001 ||
            o_m_axis_tdata[63:32] == 32'h7FFFFFFF || o_m_axis_tdata[63:32] == 32'h80000001)
        else $error("saturation flag without a clipped component");

endmodule

`default_nettype wire

FILE: sim/tb_lennard_jones_pair_impulse.sv
// Self-checking testbench for the Lennard-Jones pair impulse pipeline: streams particle pairs
// through the block and checks every result against a built-in bit-exact predictor.
// Depends on ljpi_pkg and lennard_jones_pair_impulse under hw/rtl.
`default_nettype none

module tb_lennard_jones_pair_impulse import ljpi_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint MAXMAG_L = 64'h7FFF_FFFF;

    // one expected result item
    typedef struct {
        bit [31:0] imp_x;
        bit [31:0] imp_y;
        bit        in_cut;
        bit        sat;
    } t_impulse;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [127:0] i_s_axis_tdata;   // first_x, first_y, second_x, second_y
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [63:0]  o_m_axis_tdata;   // impulse_x, impulse_y
    logic [1:0]   o_m_axis_tuser;   // within_cutoff, saturated
    logic         i_cfg_we;
    logic [1:0]   i_cfg_index;
    logic [30:0]  i_cfg_data;

    // predictor copy of the registers
    bit [30:0] box_w, box_h, cut_sq;
    bit [23:0] dt;

    bit [127:0] pair_queue[$];
    t_impulse   impulse_queue[$];
    int         n_sent, n_recv, n_fail, n_within, n_sat;
    int         hold_left;
    bit         hold_done;

    lennard_jones_pair_impulse i_dut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #3ms;
        $display("timeout at %0t, %0d items still expected", $time, impulse_queue.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // single minimum-image correction
    function automatic longint wrap_axis(longint d, bit [30:0] len);
        longint l;
        l = longint'(len);
        if (2 * d < -l) begin
            d = d + l;
        end else if (2 * d > l) begin
            d = d - l;
        end
        return d;
    endfunction

    // floor(p*y / 2^sh) clipped to the magnitude limit
    function automatic bit [63:0] shrink_mag(bit [63:0] p, bit [63:0] y, int sh, ref bit sat);
        bit [127:0] prod;
        bit [127:0] r;
        prod = {64'd0, p} * {64'd0, y};
        if (sh < 0) begin
            sat = 1'b1;
            return MAXMAG_L;
        end
        r = (sh >= 128) ? 128'd0 : (prod >> sh);
        if (r > 128'(MAXMAG_L)) begin
            sat = 1'b1;
            return MAXMAG_L;
        end
        return r[63:0];
    endfunction

    // expected impulse for one packed pair
    function automatic t_impulse pair_impulse(bit [127:0] pk);
        t_impulse  res;
        longint    d[2];
        bit [63:0] a[2];
        bit [63:0] r2, t, m, rcp, v, v2, v3, v4, v7, big, ymag, p, mag;
        longint    y;
        bit        yneg, sat, neg;
        int        len, e, f, sh;
        bit [31:0] comp[2];
        d[0] = wrap_axis(longint'($signed(pk[95:64])) - longint'($signed(pk[31:0])), box_w);
        d[1] = wrap_axis(longint'($signed(pk[127:96])) - longint'($signed(pk[63:32])), box_h);
        for (int k = 0; k < 2; k++) begin
            a[k] = (d[k] < 0) ? 64'(-d[k]) : 64'(d[k]);
            comp[k] = '0;
        end
        res = '{0, 0, 0, 0};
        sat = 1'b0;
        if (a[0] > 64'h100_0000 || a[1] > 64'h100_0000) begin
            return res;
        end
        r2 = a[0] * a[0] + a[1] * a[1];
        if (r2 > ({33'd0, cut_sq} << 16)) begin
            return res;
        end
        res.in_cut = 1'b1;
        if (r2 <= 64'h100_0000) begin
            // very close pair: clip against the separation
            for (int k = 0; k < 2; k++) begin
                if (dt != 0 && a[k] != 0) begin
                    sat = 1'b1;
                    comp[k] = (d[k] > 0) ? 32'h8000_0001 : 32'h7FFF_FFFF;
                end
            end
        end else begin
            len = 0;
            for (t = r2; t != 0; t = t >> 1) begin
                len++;
            end
            e = len - 32;
            m = (e >= 0) ? (r2 >> e) : (r2 << (-e));
            rcp = 64'h7FFF_FFFF_FFFF_FFFF / m;
            v = rcp >> 7;
            v2 = (v * v) >> 24;
            v3 = (v2 * v) >> 24;
            v4 = (v2 * v2) >> 24;
            v7 = (v4 * v3) >> 24;
            big = 48 * v7;
            big = (e < 0) ? (big << (-3 * e)) : (big >> (3 * e));
            y = longint'(24 * v4) - longint'(big);
            yneg = y < 0;
            ymag = yneg ? 64'(-y) : 64'(y);
            f = 0;
            while (ymag >= 64'h1_0000_0000) begin
                ymag = ymag >> 1;
                f++;
            end
            sh = 48 + 4 * e - f;
            for (int k = 0; k < 2; k++) begin
                p = 64'(dt) * a[k];
                mag = 0;
                if (p != 0 && ymag != 0) begin
                    mag = shrink_mag(p, ymag, sh, sat);
                end
                neg = yneg != (d[k] < 0);
                comp[k] = neg ? 32'(-mag) : 32'(mag);
            end
        end
        res.imp_x = comp[0];
        res.imp_y = comp[1];
        res.sat = sat;
        return res;
    endfunction

    // sender: presents queued pairs, predicts each one as it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= '0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                impulse_queue = {impulse_queue, pair_impulse(i_s_axis_tdata)};
                n_sent++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (pair_queue.size() != 0 &&
                    ((n_sent >= 400 && n_sent < 560) || $urandom_range(0, 99) >= 12)) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= pair_queue.pop_front();
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each result item and applies backpressure
    always @(posedge i_clk) begin
        t_impulse want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            hold_left = 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                n_recv++;
                if (impulse_queue.size() == 0) begin
                    $display("%0t: unexpected result %h/%b", $time, o_m_axis_tdata,
                             o_m_axis_tuser);
                    n_fail++;
                end else begin
                    want = impulse_queue.pop_front();
                    n_within += want.in_cut;
                    n_sat += want.sat;
                    if (o_m_axis_tdata[31:0] != want.imp_x) begin
                        $display("%0t: impulse_x expected %h got %h", $time, want.imp_x,
                                 o_m_axis_tdata[31:0]);
                        n_fail++;
                    end
                    if (o_m_axis_tdata[63:32] != want.imp_y) begin
                        $display("%0t: impulse_y expected %h got %h", $time, want.imp_y,
                                 o_m_axis_tdata[63:32]);
                        n_fail++;
                    end
                    if (o_m_axis_tuser[0] != want.in_cut) begin
                        $display("%0t: within_cutoff expected %b got %b", $time,
                                 want.in_cut, o_m_axis_tuser[0]);
                        n_fail++;
                    end
                    if (o_m_axis_tuser[1] != want.sat) begin
                        $display("%0t: saturated expected %b got %b", $time, want.sat,
                                 o_m_axis_tuser[1]);
                        n_fail++;
                    end
                end
            end
            // one long hold-off mid phase so the pipeline fills and stalls its input
            if (!hold_done && n_recv == 500) begin
                hold_done = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= (n_recv >= 400 && n_recv < 560) ||
                                   ($urandom_range(0, 99) >= 12);
            end
        end
    end

    task automatic reg_write(t_cfg_index idx, bit [30:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_BOX_WIDTH:  box_w = val;
            CFG_BOX_HEIGHT: box_h = val;
            CFG_CUTOFF_SQ:  cut_sq = val;
            default:        dt = val[23:0];
        endcase
    endtask

    task automatic set_regs(bit [30:0] bw, bit [30:0] bh, bit [30:0] cs, bit [30:0] ts);
        reg_write(CFG_BOX_WIDTH, bw);
        reg_write(CFG_BOX_HEIGHT, bh);
        reg_write(CFG_CUTOFF_SQ, cs);
        reg_write(CFG_TIME_STEP, ts);
    endtask

    function automatic bit [127:0] pack_pair(bit [31:0] ax, bit [31:0] ay, bit [31:0] bx,
                                             bit [31:0] by);
        return {by, bx, ay, ax};
    endfunction

    // pair with a random base and a separation of random scale
    function automatic bit [127:0] near_pair();
        bit [31:0] ax, ay, ox, oy;
        ax = $urandom;
        ay = $urandom;
        if ($urandom_range(0, 9) == 0) begin
            return pack_pair(ax, ay, $urandom, $urandom);
        end
        ox = $urandom & ((32'd1 << $urandom_range(0, 27)) - 1);
        oy = $urandom & ((32'd1 << $urandom_range(0, 27)) - 1);
        if ($urandom_range(0, 1)) ox = -ox;
        if ($urandom_range(0, 1)) oy = -oy;
        return pack_pair(ax, ay, ax + ox, ay + oy);
    endfunction

    // wait until the block is drained, then let the pipeline settle
    task automatic drain();
        while (pair_queue.size() != 0 || impulse_queue.size() != 0 || i_s_axis_tvalid) begin
            @(posedge i_clk);
        end
        repeat (60) @(posedge i_clk);
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) begin
            pair_queue = {pair_queue, near_pair()};
        end
        drain();
    endtask

    // queue one directed pair
    task automatic add_pair(bit [127:0] pk);
        pair_queue = {pair_queue, pk};
    endtask

    // stimulus
    initial begin
        i_rst_n   = 1'b0;
        i_cfg_we  = 1'b0;
        i_cfg_index = CFG_BOX_WIDTH;
        i_cfg_data  = '0;
        box_w  = BOX_RESET;
        box_h  = BOX_RESET;
        cut_sq = CUTOFF_RESET;
        dt     = TS_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed pairs under the reset settings
        add_pair(pack_pair(0, 0, 0, 0));                                    // coincident
        add_pair(pack_pair(32'h8000_0000, 32'h7FFF_FFFF,
                           32'h8000_0000, 32'h7FFF_FFFF));
        add_pair(pack_pair(0, 0, 32'h100, 32'hFFFF_FF00));                  // very close
        add_pair(pack_pair(0, 0, 32'h1000, 0));                             // near limit
        add_pair(pack_pair(0, 0, 32'h8000, 32'h8000));                      // half box
        add_pair(pack_pair(0, 0, 32'h8001, 32'hFFFF_7FFF));                 // wraps
        add_pair(pack_pair(32'h7FFF_FFFF, 32'h8000_0000,
                           32'h8000_0000, 32'h7FFF_FFFF));
        add_pair(pack_pair(32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h4000));
        drain();

        // large box: far pairs, cutoff edge, attractive and repulsive range
        set_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        add_pair(pack_pair(0, 0, 32'h100_0001, 0));                         // far
        add_pair(pack_pair(0, 0, 32'h100_0000, 0));
        add_pair(pack_pair(0, 0, 32'h0001_1F00, 32'h0000_8000));
        add_pair(pack_pair(32'h8000_0000, 32'h8000_0000,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF));
        drain();
        set_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h9_0000, 31'h1_0000);
        add_pair(pack_pair(0, 0, 32'h3_0000, 0));                           // on cutoff
        add_pair(pack_pair(0, 0, 32'h3_0001, 0));                           // just beyond
        add_pair(pack_pair(0, 0, 32'h1_2000, 32'h1_0000));
        drain();
        set_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h9_0000, 31'h0);          // zero dt
        add_pair(pack_pair(0, 0, 32'h100, 32'h200));
        add_pair(pack_pair(0, 0, 32'h1_0000, 32'h8000));
        drain();

        // random phases across register settings
        set_regs(BOX_RESET, BOX_RESET, CUTOFF_RESET, 31'(TS_RESET));
        random_phase(160);
        set_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        random_phase(140);
        set_regs(31'h0, 31'h0, 31'h40_0000, 31'h1);                         // no wrap
        random_phase(110);
        set_regs(31'h1, 31'h1, 31'h0, 31'($urandom));                       // tiny box
        random_phase(40);
        set_regs(31'($urandom_range(1, 32'h40_0000)), 31'($urandom_range(1, 32'h40_0000)),
                 31'($urandom), 31'($urandom));
        random_phase(200);
        set_regs(31'h8_0000, 31'h30_0000, 31'h7FFF_FFFF, 31'h00FF_FFFF);
        random_phase(160);
        set_regs(31'h100_0000, 31'h2_0000, 31'h5_0000, 31'($urandom_range(1, 32'h1000)));
        random_phase(120);

        $display("sent %0d pairs, checked %0d results (%0d within cutoff, %0d saturated)",
                 n_sent, n_recv, n_within, n_sat);
        $display("covered box, cutoff and time-step extremes with random stalls");
        if (n_fail == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
hw/rtl/ljpi_pkg.sv
hw/rtl/ljpi_recip.sv
hw/rtl/ljpi_scale.sv
hw/rtl/ljpi_skid.sv
hw/rtl/lennard_jones_pair_impulse.sv
sim/tb_lennard_jones_pair_impulse.sv
